// File: rtl/core/pls_pkg.sv
// shared types and constants for the path lookahead point search
`default_nettype none

package pls_pkg;

  // fixed field widths
  localparam int OPCODE_BITS    = 2;
  localparam int LOOKAHEAD_BITS = 23;
  localparam int TIMEOUT_BITS   = 16;
  localparam int AGE_BITS       = 16;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 23;

  // register reset values
  localparam logic [LOOKAHEAD_BITS-1:0] LOOKAHEAD_RESET = 23'd819;
  localparam logic [TIMEOUT_BITS-1:0]   TIMEOUT_RESET   = 16'd500;

  // item opcodes
  localparam logic [OPCODE_BITS-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_APPEND = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_QUERY  = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOOKAHEAD = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT   = 1'd1;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_REACH = 5'b00010,
    S_SETUP = 5'b00100,
    S_SCAN  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/pls_ram.sv
// generic single write port ram with registered read
`default_nettype none

module pls_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/path_lookahead_point_search.sv
// Path lookahead point search: stores a path and picks a pure pursuit target.
// Input channel (in_valid/in_ready) takes clear, append and query items.
// A clear or append item is done while idle and gives no result; an append
// to a full path is dropped, and an unused opcode is ignored.
// A query gives exactly one result item on the output channel
// (out_valid/out_ready). A stale pose or an empty path answers without a scan.
// Otherwise the block scans the stored points once, through a single shared
// squaring multiplier used twice per point (x then y), with the path memory
// read once per point.
// The same multiplier first squares the lookahead radius.
// The closest point and the first later point at or beyond the lookahead
// radius are tracked together in that one pass.
// in_ready is high only while idle, so one item is in work at a time; a
// result waits in the output register until out_ready, blocking new items.
// Configuration writes (cfg_write) must be made while idle; unchecked here.
// Reset empties the path and restores the default registers; no clearing
// pass is needed since only written entries are read.
`default_nettype none

module path_lookahead_point_search #(
  parameter int PATH_DEPTH = 1024,
  parameter int COORD_BITS = 24
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // configuration
  input  wire logic                                  cfg_write,
  input  wire logic [pls_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [pls_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  // input channel
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [pls_pkg::OPCODE_BITS-1:0]       opcode,
  input  wire logic signed [COORD_BITS-1:0]          point_x,
  input  wire logic signed [COORD_BITS-1:0]          point_y,
  input  wire logic                                  odometry_seen,
  input  wire logic [pls_pkg::AGE_BITS-1:0]          odometry_age,
  // output channel
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic                                       target_found,
  output logic signed [COORD_BITS-1:0]               goal_x,
  output logic signed [COORD_BITS-1:0]               goal_y
);

  import pls_pkg::*;

  localparam int LW = $clog2(PATH_DEPTH + 1);
  localparam int AW = $clog2(PATH_DEPTH);
  localparam int MW = (COORD_BITS > LOOKAHEAD_BITS) ? COORD_BITS : LOOKAHEAD_BITS;
  localparam int PW = 2 * MW;
  localparam int DW = PW + 1;

  state_t state;

  // configuration registers
  logic [LOOKAHEAD_BITS-1:0] lookahead;
  logic [TIMEOUT_BITS-1:0]   timeout;

  // control
  logic [LW-1:0] path_length;
  logic [LW-1:0] rd_idx;
  logic          ph;
  logic          s0_v, s1_v, s2_v;
  logic          have_best;
  logic          cand_v;

  // datapath
  logic signed [COORD_BITS-1:0] vx, vy;
  logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
  logic signed [COORD_BITS-1:0] cand_x, cand_y;
  logic [COORD_BITS-1:0]        ax, ay;
  logic [MW-1:0]                mul_in;
  logic [PW-1:0]                prod;
  logic [PW-1:0]                sqx;
  logic [PW-1:0]                reach;
  logic [DW-1:0]                sq_sum;
  logic [DW-1:0]                best_d;

  // memory ports
  logic                         wr_en;
  logic                         rd_en;
  logic [2*COORD_BITS-1:0]      rd_data;
  logic signed [COORD_BITS-1:0] ram_x, ram_y;
  logic signed [COORD_BITS:0]   dx, dy;

  logic in_fire;
  logic stale;
  logic path_full;
  logic cmp_en;
  logic take_best;
  logic take_cand;
  logic scan_done;

  // handshake and decode
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign path_full = (path_length == LW'(PATH_DEPTH));
  assign stale     = !odometry_seen || (odometry_age > timeout) || (path_length == '0);
  assign wr_en     = in_fire && (opcode == OP_APPEND) && !path_full;
  assign rd_en     = (state == S_SCAN) && !ph && (rd_idx != path_length);

  // compare stage: first point seeds the best, later points update it
  assign cmp_en    = (state == S_SCAN) && ph && s2_v;
  assign take_best = cmp_en && (!have_best || (sq_sum < best_d));
  assign take_cand = cmp_en && !take_best && !cand_v && (sq_sum >= DW'(reach));
  assign scan_done = (state == S_SCAN) && ph && !s0_v && !s1_v && !s2_v &&
                     (rd_idx == path_length);

  pls_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (PATH_DEPTH)
  ) u_path_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (path_length[AW-1:0]),
    .wr_data ({point_x, point_y}),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  assign ram_x = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign ram_y = rd_data[COORD_BITS-1:0];

  // signed differences to the vehicle pose
  assign dx = {ram_x[COORD_BITS-1], ram_x} - {vx[COORD_BITS-1], vx};
  assign dy = {ram_y[COORD_BITS-1], ram_y} - {vy[COORD_BITS-1], vy};

  // shared squaring unit operand select
  always_comb begin
    if (state == S_REACH) begin
      mul_in = MW'(lookahead);
    end else if (ph) begin
      mul_in = MW'(ay);
    end else begin
      mul_in = MW'(ax);
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      lookahead   <= LOOKAHEAD_RESET;
      timeout     <= TIMEOUT_RESET;
      path_length <= '0;
      rd_idx      <= '0;
      ph          <= 1'b0;
      s0_v        <= 1'b0;
      s1_v        <= 1'b0;
      s2_v        <= 1'b0;
      have_best   <= 1'b0;
      cand_v      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_LOOKAHEAD: lookahead <= cfg_data[LOOKAHEAD_BITS-1:0];
          REG_TIMEOUT:   timeout   <= cfg_data[TIMEOUT_BITS-1:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (opcode)
              OP_CLEAR: path_length <= '0;
              OP_APPEND: begin
                if (!path_full) begin
                  path_length <= path_length + LW'(1);
                end
              end
              OP_QUERY: begin
                if (stale) begin
                  out_valid <= 1'b1;
                  state     <= S_OUT;
                end else begin
                  state <= S_REACH;
                end
              end
              default: ;
            endcase
          end
        end
        S_REACH: state <= S_SETUP;
        S_SETUP: begin
          rd_idx    <= '0;
          ph        <= 1'b0;
          s0_v      <= 1'b0;
          s1_v      <= 1'b0;
          s2_v      <= 1'b0;
          have_best <= 1'b0;
          cand_v    <= 1'b0;
          state     <= S_SCAN;
        end
        S_SCAN: begin
          ph <= ~ph;
          if (!ph) begin
            // issue a read only in this phase
            s0_v <= rd_en;
            if (rd_en) begin
              rd_idx <= rd_idx + LW'(1);
            end
          end else begin
            s1_v <= s0_v;
            s2_v <= s1_v;
            if (take_best) begin
              have_best <= 1'b1;
              cand_v    <= 1'b0;
            end else if (take_cand) begin
              cand_v <= 1'b1;
            end
            if (scan_done) begin
              out_valid <= 1'b1;
              state     <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // vehicle pose capture
    if (in_fire && (opcode == OP_QUERY)) begin
      vx <= point_x;
      vy <= point_y;
    end

    // shared squaring unit
    prod <= PW'(mul_in * mul_in);

    // lookahead squared
    if (state == S_SETUP) begin
      reach <= prod;
    end

    // scan pipeline
    if (state == S_SCAN) begin
      if (ph) begin
        ax  <= dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ay  <= dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        x1  <= ram_x;
        y1  <= ram_y;
        x2  <= x1;
        y2  <= y1;
        sqx <= prod;
      end else begin
        sq_sum <= DW'(sqx) + DW'(prod);
      end
    end

    // best and candidate tracking
    if (take_best) begin
      best_d <= sq_sum;
    end
    if (take_cand) begin
      cand_x <= x2;
      cand_y <= y2;
    end

    // result register
    if (in_fire && (opcode == OP_QUERY) && stale) begin
      target_found <= 1'b0;
      goal_x       <= '0;
      goal_y       <= '0;
    end else if (scan_done) begin
      target_found <= cand_v;
      goal_x       <= cand_v ? cand_x : '0;
      goal_y       <= cand_v ? cand_y : '0;
    end
  end

endmodule

`default_nettype wire
